[src/bfbe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfbe_pkg
// Shared codes, command classes and the work record passed from front to back.
// ----------------------------------------------------------------------------
package bfbe_pkg;

    localparam logic [2:0] OP_BUF_WR = 3'd0;
    localparam logic [2:0] OP_BUF_RD = 3'd1;
    localparam logic [2:0] OP_FL_WR  = 3'd2;
    localparam logic [2:0] OP_FL_RD  = 3'd3;
    localparam logic [2:0] OP_CALL   = 3'd4;

    localparam logic [15:0] ENT_RESET   = 16'h0000;
    localparam logic [15:0] ENT_WRITE_A = 16'h0100;
    localparam logic [15:0] ENT_WRITE_B = 16'h0108;
    localparam logic [15:0] ENT_VERIFY  = 16'h0110;
    localparam logic [15:0] ENT_READ    = 16'h0120;
    localparam logic [15:0] ENT_TIMER   = 16'h0130;

    localparam logic [15:0] PC_NONE    = 16'h0000;
    localparam logic [15:0] PC_WRITE_A = 16'h0105;
    localparam logic [15:0] PC_WRITE_B = 16'h010b;
    localparam logic [15:0] PC_VERIFY  = 16'h0115;
    localparam logic [15:0] PC_READ    = 16'h0125;
    localparam logic [15:0] PC_TIMER   = 16'h0139;

    localparam logic [7:0] STATUS_REFUSED = 8'hff;

    localparam int BUF_IDX_W  = 8;
    localparam int FL_ADDR_W  = 17;
    localparam int GAME_CFG_W = 9;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_BUF_WR,
        CMD_BUF_RD,
        CMD_FL_WR,
        CMD_FL_RD,
        CMD_BLK_WR,
        CMD_VERIFY,
        CMD_BLK_RD,
        CMD_TIMER
    } cmd_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [15:0]            return_pc;
        logic                   unknown;
        logic [FL_ADDR_W-1:0]   flash_addr;
        logic [BUF_IDX_W-1:0]   buf_idx;
        logic [7:0]             wdata;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_LOOP,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[src/bfbe_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfbe_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/bfbe_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfbe_front
// Accepts input beats, decodes op and entry into a command, and holds
// decoded work in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bfbe_front #(
    parameter int BLOCK_LEN = 128
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_op,
    input  wire logic [15:0]   s_entry_address,
    input  wire logic          s_flash_bank,
    input  wire logic [15:0]   s_flash_address,
    input  wire logic [6:0]    s_buffer_index,
    input  wire logic [7:0]    s_write_data,
    output logic               q_valid,
    output bfbe_pkg::work_t    q_item,
    input  wire logic          q_pop
);
    import bfbe_pkg::*;

    localparam logic [10:0] LEN1 = 11'(BLOCK_LEN);
    localparam logic [10:0] LEN2 = 11'(2 * BLOCK_LEN);
    localparam logic [10:0] LEN4 = 11'(4 * BLOCK_LEN);

    work_t       item;
    logic [10:0] idx_w;
    logic        push;

    work_t       q_mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // index modulo buffer length, at most seven multiples to strip
    always_comb begin
        idx_w = {4'b0, s_buffer_index};
        if (idx_w >= LEN4) begin
            idx_w = idx_w - LEN4;
        end
        if (idx_w >= LEN2) begin
            idx_w = idx_w - LEN2;
        end
        if (idx_w >= LEN1) begin
            idx_w = idx_w - LEN1;
        end
    end

    always_comb begin
        item.cmd        = CMD_NONE;
        item.return_pc  = PC_NONE;
        item.unknown    = 1'b0;
        item.flash_addr = {s_flash_bank, s_flash_address};
        item.buf_idx    = idx_w[BUF_IDX_W-1:0];
        item.wdata      = s_write_data;
        case (s_op)
            OP_BUF_WR: item.cmd = CMD_BUF_WR;
            OP_BUF_RD: item.cmd = CMD_BUF_RD;
            OP_FL_WR:  item.cmd = CMD_FL_WR;
            OP_FL_RD:  item.cmd = CMD_FL_RD;
            OP_CALL: begin
                case (s_entry_address)
                    ENT_RESET: item.cmd = CMD_NONE;
                    ENT_WRITE_A: begin
                        item.cmd       = CMD_BLK_WR;
                        item.return_pc = PC_WRITE_A;
                    end
                    ENT_WRITE_B: begin
                        item.cmd       = CMD_BLK_WR;
                        item.return_pc = PC_WRITE_B;
                    end
                    ENT_VERIFY: begin
                        item.cmd       = CMD_VERIFY;
                        item.return_pc = PC_VERIFY;
                    end
                    ENT_READ: begin
                        item.cmd       = CMD_BLK_RD;
                        item.return_pc = PC_READ;
                    end
                    ENT_TIMER: begin
                        item.cmd       = CMD_TIMER;
                        item.return_pc = PC_TIMER;
                    end
                    default: item.unknown = 1'b1;
                endcase
            end
            default: item.cmd = CMD_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

[src/bfbe_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfbe_back
// Executes queued commands against the flash store and block buffer,
// walks block calls one byte per cycle, and holds the result beat.
// ----------------------------------------------------------------------------
module bfbe_back #(
    parameter int FLASH_BYTES      = 131072,
    parameter int BLOCK_LEN        = 128,
    parameter int GAME_BLOCK_BYTES = 512
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfbe_pkg::GAME_CFG_W-1:0]   cfg_data,
    input  wire logic                              q_valid,
    input  wire bfbe_pkg::work_t                   q_item,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_read_data,
    output logic [15:0]                            m_return_pc,
    output logic [7:0]                             m_status,
    output logic                                   m_status_written,
    output logic                                   m_second_tick,
    output logic                                   m_unknown_entry
);
    import bfbe_pkg::*;

    localparam int FW = $clog2(FLASH_BYTES);
    localparam int CW = $clog2(BLOCK_LEN);
    localparam int LW = GAME_CFG_W + $clog2(GAME_BLOCK_BYTES);
    localparam logic [FL_ADDR_W:0] FLASH_SIZE = (FL_ADDR_W + 1)'(FLASH_BYTES);
    localparam logic [CW-1:0]      LAST_IDX   = CW'(BLOCK_LEN - 1);

    function automatic logic [FW-1:0] flash_slot(input logic [FL_ADDR_W-1:0] a);
        logic [FL_ADDR_W:0] w;
        w = {1'b0, a};
        if (w >= FLASH_SIZE) begin
            w = w - FLASH_SIZE;
        end
        return w[FW-1:0];
    endfunction

    state_t                  state_reg, state_next;
    work_t                   cur_reg, cur_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    logic [CW-1:0]           pend_idx_reg, pend_idx_next;
    logic [FW-1:0]           pend_fl_reg, pend_fl_next;
    logic [7:0]              res_rd_reg, res_rd_next;
    logic [7:0]              res_st_reg, res_st_next;
    logic                    res_tick_reg, res_tick_next;
    logic                    half_reg, half_next;
    logic [GAME_CFG_W-1:0]   game_blocks_reg;
    logic                    m_valid_reg, m_valid_next;
    logic                    out_load;

    logic [7:0]              out_read_data_reg;
    logic [15:0]             out_return_pc_reg;
    logic [7:0]              out_status_reg;
    logic                    out_status_written_reg;
    logic                    out_second_tick_reg;
    logic                    out_unknown_entry_reg;

    logic [7:0]              page_lo;
    logic [FL_ADDR_W-1:0]    page_addr;
    logic [FW-1:0]           iter_slot;
    logic [FW-1:0]           direct_slot;
    logic [CW-1:0]           cur_bidx;
    logic [LW-1:0]           game_limit;
    logic                    over_limit;
    logic [7:0]              vxor;
    logic                    process_pend;

    logic                    fl_we;
    logic [FW-1:0]           fl_waddr, fl_raddr;
    logic [7:0]              fl_wdata, fl_rdata;
    logic                    buf_we;
    logic [CW-1:0]           buf_waddr, buf_raddr;
    logic [7:0]              buf_wdata, buf_rdata;

    bfbe_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_flash (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    bfbe_ram #(.WIDTH(8), .DEPTH(BLOCK_LEN)) u_buffer (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    assign cfg_ready   = 1'b1;
    assign page_lo     = cur_reg.flash_addr[7:0] + 8'(cnt_reg);
    assign page_addr   = {cur_reg.flash_addr[FL_ADDR_W-1:8], page_lo};
    assign iter_slot   = flash_slot(page_addr);
    assign direct_slot = flash_slot(cur_reg.flash_addr);
    assign cur_bidx    = cur_reg.buf_idx[CW-1:0];
    assign game_limit  = LW'(game_blocks_reg) * LW'(GAME_BLOCK_BYTES);
    assign over_limit  = LW'(cur_reg.flash_addr) >= game_limit;
    assign vxor        = fl_rdata ^ buf_rdata;

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pend_fl_next  = pend_fl_reg;
        res_rd_next   = res_rd_reg;
        res_st_next   = res_st_reg;
        res_tick_next = res_tick_reg;
        half_next     = half_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_load      = 1'b0;
        q_pop         = 1'b0;
        process_pend  = 1'b0;

        fl_we     = 1'b0;
        fl_waddr  = pend_fl_reg;
        fl_wdata  = buf_rdata;
        fl_raddr  = iter_slot;
        buf_we    = 1'b0;
        buf_waddr = pend_idx_reg;
        buf_wdata = fl_rdata;
        buf_raddr = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    cur_next      = q_item;
                    res_rd_next   = 8'd0;
                    res_st_next   = 8'd0;
                    res_tick_next = 1'b0;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_DONE;
                case (cur_reg.cmd)
                    CMD_BUF_WR: begin
                        buf_we    = 1'b1;
                        buf_waddr = cur_bidx;
                        buf_wdata = cur_reg.wdata;
                    end
                    CMD_BUF_RD: begin
                        buf_raddr  = cur_bidx;
                        state_next = ST_READ;
                    end
                    CMD_FL_WR: begin
                        fl_we    = 1'b1;
                        fl_waddr = direct_slot;
                        fl_wdata = cur_reg.wdata;
                    end
                    CMD_FL_RD: begin
                        fl_raddr   = direct_slot;
                        state_next = ST_READ;
                    end
                    CMD_BLK_WR: begin
                        if (over_limit) begin
                            res_st_next = STATUS_REFUSED;
                        end else begin
                            state_next = ST_LOOP;
                        end
                    end
                    CMD_VERIFY: state_next = ST_LOOP;
                    CMD_BLK_RD: state_next = ST_LOOP;
                    CMD_TIMER: begin
                        half_next     = ~half_reg;
                        res_tick_next = half_reg;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_READ: begin
                res_rd_next = (cur_reg.cmd == CMD_BUF_RD) ? buf_rdata : fl_rdata;
                state_next  = ST_DONE;
            end
            ST_LOOP: begin
                pend_next     = 1'b1;
                pend_idx_next = cnt_reg;
                pend_fl_next  = iter_slot;
                cnt_next      = cnt_reg + CW'(1);
                process_pend  = pend_reg;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                process_pend = 1'b1;
                state_next   = ST_DONE;
                if (cur_reg.cmd == CMD_VERIFY) begin
                    res_st_next = vxor;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // byte read last cycle is now on the RAM outputs
        if (process_pend) begin
            case (cur_reg.cmd)
                CMD_BLK_WR: fl_we  = 1'b1;
                CMD_BLK_RD: buf_we = 1'b1;
                CMD_VERIFY: begin
                    if (vxor != 8'd0) begin
                        res_st_next = vxor;
                        state_next  = ST_DONE;
                    end
                end
                default: fl_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pend_reg        <= 1'b0;
            half_reg        <= 1'b0;
            game_blocks_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                game_blocks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        pend_idx_reg <= pend_idx_next;
        pend_fl_reg  <= pend_fl_next;
        res_rd_reg   <= res_rd_next;
        res_st_reg   <= res_st_next;
        res_tick_reg <= res_tick_next;
        if (out_load) begin
            out_read_data_reg      <= res_rd_reg;
            out_return_pc_reg      <= cur_reg.return_pc;
            out_status_reg         <= res_st_reg;
            out_status_written_reg <= (cur_reg.cmd == CMD_BLK_WR) ||
                                      (cur_reg.cmd == CMD_VERIFY);
            out_second_tick_reg    <= res_tick_reg;
            out_unknown_entry_reg  <= cur_reg.unknown;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = out_read_data_reg;
    assign m_return_pc      = out_return_pc_reg;
    assign m_status         = out_status_reg;
    assign m_status_written = out_status_written_reg;
    assign m_second_tick    = out_second_tick_reg;
    assign m_unknown_entry  = out_unknown_entry_reg;

endmodule
`default_nettype wire

[src/bios_flash_block_engine.sv]
`default_nettype none
// Block calls walk the block one byte per cycle through the flash RAM port.
// A two-entry queue decouples input.
// Reset clears control state, the half-second flag and game_blocks; flash store and
// block buffer are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// bios_flash_block_engine
// Firmware-call trap engine: block buffer, flash store and timer flag.
// ----------------------------------------------------------------------------
module bios_flash_block_engine #(
    parameter int FLASH_BYTES      = 131072,
    parameter int BLOCK_LEN        = 128,
    parameter int GAME_BLOCK_BYTES = 512
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [8:0]    cfg_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_op,
    input  wire logic [15:0]   s_entry_address,
    input  wire logic          s_flash_bank,
    input  wire logic [15:0]   s_flash_address,
    input  wire logic [6:0]    s_buffer_index,
    input  wire logic [7:0]    s_write_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_read_data,
    output logic [15:0]        m_return_pc,
    output logic [7:0]         m_status,
    output logic               m_status_written,
    output logic               m_second_tick,
    output logic               m_unknown_entry
);
    import bfbe_pkg::*;

    logic  q_valid;
    logic  q_pop;
    work_t q_item;

    bfbe_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_entry_address (s_entry_address),
        .s_flash_bank    (s_flash_bank),
        .s_flash_address (s_flash_address),
        .s_buffer_index  (s_buffer_index),
        .s_write_data    (s_write_data),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    bfbe_back #(
        .FLASH_BYTES      (FLASH_BYTES),
        .BLOCK_LEN        (BLOCK_LEN),
        .GAME_BLOCK_BYTES (GAME_BLOCK_BYTES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_return_pc      (m_return_pc),
        .m_status         (m_status),
        .m_status_written (m_status_written),
        .m_second_tick    (m_second_tick),
        .m_unknown_entry  (m_unknown_entry)
    );

endmodule
`default_nettype wire
